@@ hw/rtl/ldc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, widths and register codes for the lens distortion correction pipeline.
package ldc_pkg;

    localparam int FRAC_W    = 24;   // fraction bits of the Q.24 datapath
    localparam int PT_W      = 24;   // Q1.23 point and center
    localparam int COEF_W    = 32;   // Q8.24 coefficients
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 32;

    localparam int D_W    = PT_W + 1;                  // offset from center
    localparam int SQ_SH  = 2 * (PT_W - 1) - FRAC_W;   // Q.46 -> Q.24
    localparam int SQ_W   = 28;                        // dx^2, dy^2, dx*dy in Q.24
    localparam int R2_W   = 29;
    localparam int TA_W   = 30;                        // r2 + 2*dx^2
    localparam int R4_W   = 32;
    localparam int R6_W   = 35;
    localparam int KR2_W  = 36;
    localparam int KR4_W  = 39;
    localparam int KR24_W = 40;
    localparam int K3H_W  = COEF_W + R6_W - FRAC_W;    // k3 * r6 upper part
    localparam int K3L_W  = 33;                        // k3 * r6 lower part, shifted
    localparam int RAD_W  = 42;
    localparam int TP_W   = 37;                        // p * (r2 + 2*s)
    localparam int TD_W   = 35;                        // p * dxy
    localparam int TAN_W  = 38;
    localparam int SUM_W  = 46;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL_P1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL_P2 = 3'd6;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [PT_W-1:0] image_x;
        logic signed [PT_W-1:0] image_y;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] corrected_x;
        logic signed [OUT_W-1:0] corrected_y;
        logic                    saturated;
    } t_out;

    typedef struct packed {
        logic signed [PT_W-1:0]   center_x;
        logic signed [PT_W-1:0]   center_y;
        logic signed [COEF_W-1:0] radial_k1;
        logic signed [COEF_W-1:0] radial_k2;
        logic signed [COEF_W-1:0] radial_k3;
        logic signed [COEF_W-1:0] tangential_p1;
        logic signed [COEF_W-1:0] tangential_p2;
    } t_cfg;

    // offsets and radius terms, offset stages -> radial stages
    typedef struct packed {
        logic                   valid;
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic signed [SQ_W-1:0] dxy;
        logic signed [R2_W-1:0] r2;
        logic signed [TA_W-1:0] txa;
        logic signed [TA_W-1:0] tya;
    } t_geo;

    // radial factor and tangential terms, radial stages -> output stages
    typedef struct packed {
        logic                    valid;
        logic signed [PT_W-1:0]  x;
        logic signed [PT_W-1:0]  y;
        logic signed [D_W-1:0]   dx;
        logic signed [D_W-1:0]   dy;
        logic signed [RAD_W-1:0] rad;
        logic signed [TAN_W-1:0] tx;
        logic signed [TAN_W-1:0] ty;
    } t_rad;

endpackage

@@ hw/rtl/lens_distortion_correct.sv @@
`timescale 1ns / 1ps
// Top level of the radial and tangential lens distortion correction pipeline.
//
// Usage:
//   A point (image_x, image_y, Q1.23) is transferred in at a clock edge with
//   start high and busy low. busy stays low: the pipeline takes a new point
//   every cycle, so throughput is one point per clock.
//   The corrected point (Q8.24) plus the saturated flag appears on o_result
//   for one cycle with o_done high, once the input transfer has passed the
//   ten register stages: offset, squares, r2, r4 and first coefficient
//   products, r6, split k3*r6, radial sum, split scaling products, final
//   sum, saturation.
//   The result receiver cannot stall; o_done is a strobe and the result
//   must be captured in that cycle.
//   Configuration: write i_cfg_data to register i_cfg_idx with i_cfg_we;
//   indexes 0..6 are center_x, center_y, k1, k2, k3, p1, p2, others are
//   ignored. Write only while no point is in flight.
//   Reset (i_rst_n low, synchronous) clears all registers to zero and
//   drops any points in flight.
module lens_distortion_correct (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  ldc_pkg::t_in                   i_point,
    output logic                           o_done,
    output ldc_pkg::t_out                  o_result,
    input  logic                           i_cfg_we,
    input  logic [ldc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ldc_pkg::COEF_W-1:0]     i_cfg_data
);
    import ldc_pkg::*;

    localparam int LATENCY = 10;

    t_cfg cfg;
    t_geo geo;
    t_rad rad;
    logic in_xfer;

    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    ldc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ldc_offset u_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_xfer),
        .i_pt    (i_point),
        .i_cfg   (cfg),
        .o_geo   (geo)
    );

    ldc_radial u_radial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geo   (geo),
        .i_cfg   (cfg),
        .o_rad   (rad)
    );

    ldc_apply u_apply (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rad    (rad),
        .o_done   (o_done),
        .o_result (o_result)
    );

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> ##LATENCY o_done)
        else $error("accepted point produced no result");

    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(in_xfer, LATENCY))
        else $error("result without a matching input transfer");

endmodule

@@ hw/rtl/ldc_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file: principal point and distortion coefficients.
module ldc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [ldc_pkg::CFG_IDX_W-1:0]    i_idx,
    input  logic [ldc_pkg::COEF_W-1:0]       i_data,
    output ldc_pkg::t_cfg                    o_cfg
);
    import ldc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_idx)
                REG_CENTER_X:      n_cfg.center_x = i_data[PT_W-1:0];
                REG_CENTER_Y:      n_cfg.center_y = i_data[PT_W-1:0];
                REG_RADIAL_K1:     n_cfg.radial_k1 = i_data;
                REG_RADIAL_K2:     n_cfg.radial_k2 = i_data;
                REG_RADIAL_K3:     n_cfg.radial_k3 = i_data;
                REG_TANGENTIAL_P1: n_cfg.tangential_p1 = i_data;
                REG_TANGENTIAL_P2: n_cfg.tangential_p2 = i_data;
                default:           n_cfg = r_cfg;   // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/ldc_offset.sv @@
`timescale 1ns / 1ps
// Stages 1-3: offsets from the principal point, squares and r2.
module ldc_offset (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ldc_pkg::t_in  i_pt,
    input  ldc_pkg::t_cfg i_cfg,
    output ldc_pkg::t_geo o_geo
);
    import ldc_pkg::*;

    typedef struct packed {
        logic                   valid;
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
    } t_s1;

    typedef struct packed {
        logic                   valid;
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [D_W-1:0]  dx;
        logic signed [D_W-1:0]  dy;
        logic signed [SQ_W-1:0] sx;
        logic signed [SQ_W-1:0] sy;
        logic signed [SQ_W-1:0] dxy;
    } t_s2;

    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_geo r_geo, n_geo;

    logic signed [2*D_W-1:0] prod_xx;
    logic signed [2*D_W-1:0] prod_yy;
    logic signed [2*D_W-1:0] prod_xy;
    logic signed [R2_W-1:0]  r2;

    always_comb begin
        n_s1.valid = i_valid;
        n_s1.x     = i_pt.image_x;
        n_s1.y     = i_pt.image_y;
        n_s1.dx    = D_W'(i_pt.image_x) - D_W'(i_cfg.center_x);
        n_s1.dy    = D_W'(i_pt.image_y) - D_W'(i_cfg.center_y);
    end

    assign prod_xx = r_s1.dx * r_s1.dx;
    assign prod_yy = r_s1.dy * r_s1.dy;
    assign prod_xy = r_s1.dx * r_s1.dy;

    // upper slice of a Q.46 product is its floor in Q.24
    always_comb begin
        n_s2.valid = r_s1.valid;
        n_s2.x     = r_s1.x;
        n_s2.y     = r_s1.y;
        n_s2.dx    = r_s1.dx;
        n_s2.dy    = r_s1.dy;
        n_s2.sx    = prod_xx[SQ_SH +: SQ_W];
        n_s2.sy    = prod_yy[SQ_SH +: SQ_W];
        n_s2.dxy   = prod_xy[SQ_SH +: SQ_W];
    end

    assign r2 = R2_W'(r_s2.sx) + R2_W'(r_s2.sy);

    always_comb begin
        n_geo.valid = r_s2.valid;
        n_geo.x     = r_s2.x;
        n_geo.y     = r_s2.y;
        n_geo.dx    = r_s2.dx;
        n_geo.dy    = r_s2.dy;
        n_geo.dxy   = r_s2.dxy;
        n_geo.r2    = r2;
        n_geo.txa   = TA_W'(r2) + TA_W'(r_s2.sx) + TA_W'(r_s2.sx);
        n_geo.tya   = TA_W'(r2) + TA_W'(r_s2.sy) + TA_W'(r_s2.sy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_s2  <= '0;
            r_geo <= '0;
        end else begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_geo <= n_geo;
        end
    end

    assign o_geo = r_geo;

    a_r2_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_geo.valid |-> !r_geo.r2[R2_W-1])
        else $error("r2 negative");

    a_tan_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_geo.valid |-> (r_geo.txa >= TA_W'(r_geo.r2)) && (r_geo.tya >= TA_W'(r_geo.r2)))
        else $error("tangential argument below r2");

endmodule

@@ hw/rtl/ldc_radial.sv @@
`timescale 1ns / 1ps
// Stages 4-7: powers of r2, coefficient products, radial factor and tangential terms.
module ldc_radial (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ldc_pkg::t_geo i_geo,
    input  ldc_pkg::t_cfg i_cfg,
    output ldc_pkg::t_rad o_rad
);
    import ldc_pkg::*;

    typedef struct packed {
        logic                    valid;
        logic signed [PT_W-1:0]  x;
        logic signed [PT_W-1:0]  y;
        logic signed [D_W-1:0]   dx;
        logic signed [D_W-1:0]   dy;
        logic signed [R2_W-1:0]  r2;
        logic signed [R4_W-1:0]  r4;
        logic signed [KR2_W-1:0] kr2;
        logic signed [TP_W-1:0]  tpx;
        logic signed [TP_W-1:0]  tpy;
        logic signed [TD_W-1:0]  tdx;
        logic signed [TD_W-1:0]  tdy;
    } t_s4;

    typedef struct packed {
        logic                    valid;
        logic signed [PT_W-1:0]  x;
        logic signed [PT_W-1:0]  y;
        logic signed [D_W-1:0]   dx;
        logic signed [D_W-1:0]   dy;
        logic signed [KR2_W-1:0] kr2;
        logic signed [KR4_W-1:0] kr4;
        logic signed [R6_W-1:0]  r6;
        logic signed [TAN_W-1:0] tx;
        logic signed [TAN_W-1:0] ty;
    } t_s5;

    typedef struct packed {
        logic                     valid;
        logic signed [PT_W-1:0]   x;
        logic signed [PT_W-1:0]   y;
        logic signed [D_W-1:0]    dx;
        logic signed [D_W-1:0]    dy;
        logic signed [KR24_W-1:0] kr24;
        logic signed [K3H_W-1:0]  k3h;
        logic signed [K3L_W-1:0]  k3l;
        logic signed [TAN_W-1:0]  tx;
        logic signed [TAN_W-1:0]  ty;
    } t_s6;

    t_s4  r_s4, n_s4;
    t_s5  r_s5, n_s5;
    t_s6  r_s6, n_s6;
    t_rad r_rad, n_rad;

    // stage 4 products
    logic signed [2*R2_W-1:0]        prod_r2sq;
    logic signed [COEF_W+R2_W-1:0]   prod_k1;
    logic signed [COEF_W+TA_W-1:0]   prod_p1a;
    logic signed [COEF_W+TA_W-1:0]   prod_p2b;
    logic signed [COEF_W+SQ_W-1:0]   prod_p2d;
    logic signed [COEF_W+SQ_W-1:0]   prod_p1d;
    // stage 5 products
    logic signed [R2_W+R4_W-1:0]     prod_r6;
    logic signed [COEF_W+R4_W-1:0]   prod_k2;
    // stage 6: k3 * r6 split at the binary point of r6
    logic signed [R6_W-FRAC_W-1:0]   r6_hi;
    logic signed [FRAC_W:0]          r6_lo;
    logic signed [K3H_W-1:0]         prod_k3h;
    logic signed [COEF_W+FRAC_W:0]   prod_k3l;

    assign prod_r2sq = i_geo.r2 * i_geo.r2;
    assign prod_k1   = i_cfg.radial_k1 * i_geo.r2;
    assign prod_p1a  = i_cfg.tangential_p1 * i_geo.txa;
    assign prod_p2b  = i_cfg.tangential_p2 * i_geo.tya;
    assign prod_p2d  = i_cfg.tangential_p2 * i_geo.dxy;
    assign prod_p1d  = i_cfg.tangential_p1 * i_geo.dxy;

    always_comb begin
        n_s4.valid = i_geo.valid;
        n_s4.x     = i_geo.x;
        n_s4.y     = i_geo.y;
        n_s4.dx    = i_geo.dx;
        n_s4.dy    = i_geo.dy;
        n_s4.r2    = i_geo.r2;
        n_s4.r4    = prod_r2sq[FRAC_W +: R4_W];
        n_s4.kr2   = prod_k1[FRAC_W +: KR2_W];
        n_s4.tpx   = prod_p1a[FRAC_W +: TP_W];
        n_s4.tpy   = prod_p2b[FRAC_W +: TP_W];
        n_s4.tdx   = prod_p2d[FRAC_W +: TD_W];
        n_s4.tdy   = prod_p1d[FRAC_W +: TD_W];
    end

    assign prod_r6 = r_s4.r2 * r_s4.r4;
    assign prod_k2 = i_cfg.radial_k2 * r_s4.r4;

    always_comb begin
        n_s5.valid = r_s4.valid;
        n_s5.x     = r_s4.x;
        n_s5.y     = r_s4.y;
        n_s5.dx    = r_s4.dx;
        n_s5.dy    = r_s4.dy;
        n_s5.kr2   = r_s4.kr2;
        n_s5.kr4   = prod_k2[FRAC_W +: KR4_W];
        n_s5.r6    = prod_r6[FRAC_W +: R6_W];
        // cross terms enter twice
        n_s5.tx    = TAN_W'(r_s4.tpx) + TAN_W'(r_s4.tdx) + TAN_W'(r_s4.tdx);
        n_s5.ty    = TAN_W'(r_s4.tpy) + TAN_W'(r_s4.tdy) + TAN_W'(r_s4.tdy);
    end

    assign r6_hi    = r_s5.r6[R6_W-1:FRAC_W];
    assign r6_lo    = {1'b0, r_s5.r6[FRAC_W-1:0]};
    assign prod_k3h = i_cfg.radial_k3 * r6_hi;
    assign prod_k3l = i_cfg.radial_k3 * r6_lo;

    always_comb begin
        n_s6.valid = r_s5.valid;
        n_s6.x     = r_s5.x;
        n_s6.y     = r_s5.y;
        n_s6.dx    = r_s5.dx;
        n_s6.dy    = r_s5.dy;
        n_s6.kr24  = KR24_W'(r_s5.kr2) + KR24_W'(r_s5.kr4);
        n_s6.k3h   = prod_k3h;
        n_s6.k3l   = prod_k3l[FRAC_W +: K3L_W];
        n_s6.tx    = r_s5.tx;
        n_s6.ty    = r_s5.ty;
    end

    always_comb begin
        n_rad.valid = r_s6.valid;
        n_rad.x     = r_s6.x;
        n_rad.y     = r_s6.y;
        n_rad.dx    = r_s6.dx;
        n_rad.dy    = r_s6.dy;
        n_rad.rad   = RAD_W'(r_s6.kr24) + RAD_W'(r_s6.k3h) + RAD_W'(r_s6.k3l);
        n_rad.tx    = r_s6.tx;
        n_rad.ty    = r_s6.ty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4  <= '0;
            r_s5  <= '0;
            r_s6  <= '0;
            r_rad <= '0;
        end else begin
            r_s4  <= n_s4;
            r_s5  <= n_s5;
            r_s6  <= n_s6;
            r_rad <= n_rad;
        end
    end

    assign o_rad = r_rad;

endmodule

@@ hw/rtl/ldc_apply.sv @@
`timescale 1ns / 1ps
// Stages 8-10: scale offsets by the radial factor, sum, saturate and drive the result.
module ldc_apply (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ldc_pkg::t_rad i_rad,
    output logic          o_done,
    output ldc_pkg::t_out o_result
);
    import ldc_pkg::*;

    localparam int RH_W = RAD_W - FRAC_W;
    localparam int D2_W = D_W + 1;
    localparam int MH_W = D2_W + RH_W;
    localparam int ML_W = D2_W + 1;

    typedef struct packed {
        logic                    valid;
        logic signed [D_W-1:0]   x2;
        logic signed [D_W-1:0]   y2;
        logic signed [TAN_W-1:0] tx;
        logic signed [TAN_W-1:0] ty;
        logic signed [MH_W-1:0]  mxh;
        logic signed [ML_W-1:0]  mxl;
        logic signed [MH_W-1:0]  myh;
        logic signed [ML_W-1:0]  myl;
    } t_s8;

    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] ox;
        logic signed [SUM_W-1:0] oy;
    } t_s9;

    t_s8  r_s8, n_s8;
    t_s9  r_s9, n_s9;
    logic r_done;
    t_out r_res, n_res;

    logic signed [D2_W-1:0]          d2x, d2y;
    logic signed [RH_W-1:0]          rad_hi;
    logic signed [FRAC_W:0]          rad_lo;
    logic signed [MH_W-1:0]          prod_xh, prod_yh;
    logic signed [D2_W+FRAC_W:0]     prod_xl, prod_yl;
    logic                            ovf_x, ovf_y;

    assign d2x    = D2_W'(i_rad.dx) + D2_W'(i_rad.dx);
    assign d2y    = D2_W'(i_rad.dy) + D2_W'(i_rad.dy);
    assign rad_hi = i_rad.rad[RAD_W-1:FRAC_W];
    assign rad_lo = {1'b0, i_rad.rad[FRAC_W-1:0]};

    assign prod_xh = d2x * rad_hi;
    assign prod_xl = d2x * rad_lo;
    assign prod_yh = d2y * rad_hi;
    assign prod_yl = d2y * rad_lo;

    always_comb begin
        n_s8.valid = i_rad.valid;
        n_s8.x2    = D_W'(i_rad.x) + D_W'(i_rad.x);
        n_s8.y2    = D_W'(i_rad.y) + D_W'(i_rad.y);
        n_s8.tx    = i_rad.tx;
        n_s8.ty    = i_rad.ty;
        n_s8.mxh   = prod_xh;
        n_s8.mxl   = prod_xl[FRAC_W +: ML_W];
        n_s8.myh   = prod_yh;
        n_s8.myl   = prod_yl[FRAC_W +: ML_W];
    end

    always_comb begin
        n_s9.valid = r_s8.valid;
        n_s9.ox    = SUM_W'(r_s8.x2) + SUM_W'(r_s8.mxh) + SUM_W'(r_s8.mxl) + SUM_W'(r_s8.tx);
        n_s9.oy    = SUM_W'(r_s8.y2) + SUM_W'(r_s8.myh) + SUM_W'(r_s8.myl) + SUM_W'(r_s8.ty);
    end

    // out of range when the bits above the result's sign disagree with it
    assign ovf_x = (r_s9.ox[SUM_W-1:OUT_W-1] != '0) && (r_s9.ox[SUM_W-1:OUT_W-1] != '1);
    assign ovf_y = (r_s9.oy[SUM_W-1:OUT_W-1] != '0) && (r_s9.oy[SUM_W-1:OUT_W-1] != '1);

    always_comb begin
        n_res.corrected_x = ovf_x ? (r_s9.ox[SUM_W-1] ? OUT_MIN : OUT_MAX) : r_s9.ox[OUT_W-1:0];
        n_res.corrected_y = ovf_y ? (r_s9.oy[SUM_W-1] ? OUT_MIN : OUT_MAX) : r_s9.oy[OUT_W-1:0];
        n_res.saturated   = ovf_x | ovf_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8   <= '0;
            r_s9   <= '0;
            r_res  <= '0;
            r_done <= 1'b0;
        end else begin
            r_s8   <= n_s8;
            r_s9   <= n_s9;
            r_res  <= n_res;
            r_done <= r_s9.valid;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_res.saturated |->
            (r_res.corrected_x == OUT_MAX) || (r_res.corrected_x == OUT_MIN) ||
            (r_res.corrected_y == OUT_MAX) || (r_res.corrected_y == OUT_MIN))
        else $error("saturated flag without a clipped coordinate");

endmodule

@@ dv/tb_lens_distortion_correct.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lens_distortion_correct: random points under several register settings.
module tb_lens_distortion_correct;
    import ldc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;   // out of range, must be ignored

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_in                  i_point = '0;
    logic                 o_done;
    t_out                 o_result;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [COEF_W-1:0]    i_cfg_data = '0;

    lens_distortion_correct u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_point    (i_point),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_cfg        lens_regs = '0;      // shadow of the block's registers
    t_in         points_to_send[$];
    t_out        corrected_due[$];
    int unsigned mismatch_count = 0;
    int unsigned gap_left = 0;
    bit          burst = 1'b0;

    // floor(a*b / 2^24), exact
    function automatic longint q24_mul(longint a, longint b);
        logic signed [127:0] wa, wb, prod;
        wa = a;
        wb = b;
        prod = wa * wb;
        return longint'(prod >>> FRAC_W);
    endfunction

    function automatic logic [OUT_W-1:0] clip_q24(longint v);
        if (v > longint'(OUT_MAX)) return OUT_MAX;
        if (v < longint'(OUT_MIN)) return OUT_MIN;
        return v[OUT_W-1:0];
    endfunction

    function automatic t_out correct_point(t_in p);
        longint x, y, dx, dy, sx, sy, dxy, r2, r4, r6, rad, tx, ty, ox, oy;
        t_out r;
        x   = p.image_x;
        y   = p.image_y;
        dx  = x - longint'(lens_regs.center_x);
        dy  = y - longint'(lens_regs.center_y);
        sx  = (dx * dx) >>> SQ_SH;
        sy  = (dy * dy) >>> SQ_SH;
        dxy = (dx * dy) >>> SQ_SH;
        r2  = sx + sy;
        r4  = q24_mul(r2, r2);
        r6  = q24_mul(r2, r4);
        rad = q24_mul(lens_regs.radial_k1, r2) + q24_mul(lens_regs.radial_k2, r4)
            + q24_mul(lens_regs.radial_k3, r6);
        tx  = q24_mul(lens_regs.tangential_p1, r2 + 2 * sx)
            + 2 * q24_mul(lens_regs.tangential_p2, dxy);
        ty  = q24_mul(lens_regs.tangential_p2, r2 + 2 * sy)
            + 2 * q24_mul(lens_regs.tangential_p1, dxy);
        ox  = 2 * x + q24_mul(2 * dx, rad) + tx;
        oy  = 2 * y + q24_mul(2 * dy, rad) + ty;
        r.corrected_x = clip_q24(ox);
        r.corrected_y = clip_q24(oy);
        r.saturated   = (ox > longint'(OUT_MAX)) || (ox < longint'(OUT_MIN))
                     || (oy > longint'(OUT_MAX)) || (oy < longint'(OUT_MIN));
        return r;
    endfunction

    function automatic t_in make_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y);
        t_in p;
        p.image_x = x;
        p.image_y = y;
        return p;
    endfunction

    // mostly full-range values, some extremes, some close to the principal point
    function automatic logic [PT_W-1:0] rand_coord(logic [PT_W-1:0] c);
        logic [PT_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = PT_W'($urandom());
            5, 6: begin
                case ($urandom_range(0, 3))
                    0:       v = 24'h7FFFFF;
                    1:       v = 24'h800000;
                    2:       v = 24'h000000;
                    default: v = 24'hFFFFFF;
                endcase
            end
            default: v = c + PT_W'($urandom_range(0, 8191)) - 24'd4096;
        endcase
        return v;
    endfunction

    // full range or below one in magnitude, so not every point saturates
    function automatic logic [COEF_W-1:0] rand_coef();
        logic [COEF_W-1:0] v;
        case ($urandom_range(0, 2))
            0:       v = $urandom();
            1:       v = COEF_W'($urandom_range(0, 32'h00FFFFFF));
            default: v = COEF_W'($urandom_range(0, 32'h0000FFFF));
        endcase
        if ($urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_CENTER_X:      lens_regs.center_x      = data[PT_W-1:0];
            REG_CENTER_Y:      lens_regs.center_y      = data[PT_W-1:0];
            REG_RADIAL_K1:     lens_regs.radial_k1     = data;
            REG_RADIAL_K2:     lens_regs.radial_k2     = data;
            REG_RADIAL_K3:     lens_regs.radial_k3     = data;
            REG_TANGENTIAL_P1: lens_regs.tangential_p1 = data;
            REG_TANGENTIAL_P2: lens_regs.tangential_p2 = data;
            default: ;
        endcase
    endtask

    task automatic load_config(logic [31:0] cx, logic [31:0] cy, logic [31:0] k1,
                               logic [31:0] k2, logic [31:0] k3, logic [31:0] p1,
                               logic [31:0] p2);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIAL_K1, k1);
        write_reg(REG_RADIAL_K2, k2);
        write_reg(REG_RADIAL_K3, k3);
        write_reg(REG_TANGENTIAL_P1, p1);
        write_reg(REG_TANGENTIAL_P2, p2);
        write_reg(REG_UNUSED, $urandom());
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_point(t_in p);
        points_to_send = {points_to_send, p};
    endtask

    task automatic queue_random(int count);
        for (int n = 0; n < count; n++) begin
            add_point(make_point(rand_coord(lens_regs.center_x),
                                 rand_coord(lens_regs.center_y)));
        end
    endtask

    task automatic queue_corners();
        add_point(make_point(24'h000000, 24'h000000));
        add_point(make_point(24'h7FFFFF, 24'h7FFFFF));
        add_point(make_point(24'h800000, 24'h800000));
        add_point(make_point(24'h7FFFFF, 24'h800000));
        add_point(make_point(24'h800000, 24'h7FFFFF));
        add_point(make_point(24'hFFFFFF, 24'hFFFFFF));
        add_point(make_point(24'h000001, 24'h000001));
        add_point(make_point(24'h555555, 24'hAAAAAA));
    endtask

    // sampled on the falling edge so all edge updates have settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (points_to_send.size() != 0 || start || corrected_due.size() != 0);
    endtask

    // point driver: random gaps after each transfer, with stretches of back-to-back points
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (points_to_send.size() != 0) begin
                i_point <= points_to_send.pop_front();
                start   <= 1'b1;
                if ($urandom_range(0, 47) == 0) burst = !burst;
                gap_left = burst ? 0 : $urandom_range(0, 16);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin : monitor
        t_out want;
        if (i_rst_n) begin
            if (o_done) begin
                if (corrected_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: x=%0d y=%0d sat=%0b",
                                 o_result.corrected_x, o_result.corrected_y,
                                 o_result.saturated);
                end else begin
                    want = corrected_due.pop_front();
                    if (o_result.corrected_x !== want.corrected_x ||
                        o_result.corrected_y !== want.corrected_y ||
                        o_result.saturated !== want.saturated) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: expected x=%0d y=%0d sat=%0b, ",
                                      "got x=%0d y=%0d sat=%0b"},
                                     want.corrected_x, want.corrected_y, want.saturated,
                                     o_result.corrected_x, o_result.corrected_y,
                                     o_result.saturated);
                    end
                end
            end
            if (start && !busy) corrected_due = {corrected_due, correct_point(i_point)};
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: identity scaling, result is twice the input
        queue_corners();
        queue_random(150);
        wait_drained();

        // plausible lens
        load_config(32'h00010000, 32'hFFFE0000, 32'hFFC00000, 32'h000CCCCD,
                    32'hFFFD70A4, 32'h00004189, 32'hFFFFDF3B);
        queue_random(250);
        wait_drained();

        // largest coefficients, center at the corners: drives saturation
        load_config(32'h00800000, 32'h007FFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        queue_corners();
        queue_random(150);
        wait_drained();

        load_config(32'h007FFFFF, 32'h00800000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h80000000);
        queue_random(150);
        wait_drained();

        for (int n = 0; n < 6; n++) begin
            load_config($urandom(), $urandom(), rand_coef(), rand_coef(), rand_coef(),
                        rand_coef(), rand_coef());
            queue_random(130);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && corrected_due.size() == 0) begin
            $display("tb_lens_distortion_correct passed");
        end else begin
            $display("tb_lens_distortion_correct failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_lens_distortion_correct failed");
        $finish;
    end

endmodule
